// File: hw/rtl/serial_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// serial_frame_receiver_macros
// Assertion macros shared by the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFR_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfr assertion failed");

// next-cycle implication
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfr assertion failed");

`endif

// File: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 4;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [BYTE_W-1:0] TYPE_Q          = 8'h51;
  localparam logic [BYTE_W-1:0] TYPE_R          = 8'h52;
  localparam logic [BYTE_W-1:0] TYPE_E          = 8'h45;
  localparam logic [BYTE_W-1:0] BROADCAST       = 8'hFF;
  localparam logic [BYTE_W-1:0] SOURCE_REQUIRED = 8'h00;
  localparam logic [BYTE_W-1:0] TIMEOUT_RESET   = 8'd5;

  localparam int DEST_POS = 1;
  localparam int SRC_POS  = 2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDRESS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic start;
  } sfr_ctl_t;

endpackage

// File: hw/rtl/sfr_drain.sv
// ----------------------------------------------------------------------------
// sfr_drain
// Frame store memory and readout sequencer with registered output stage.
// ----------------------------------------------------------------------------
module sfr_drain #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfr_pkg::sfr_ctl_t             ctl,
  input  logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
  input  logic [sfr_pkg::BYTE_W-1:0]    wr_data,
  output logic                          busy,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] frame_byte, [11:8] byte_index, [15:12] zero
  output logic [sfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                          out_tlast
);
  import sfr_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);

  logic [BYTE_W-1:0] store_r [FRAME_BYTES];
  logic [BYTE_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_idx_r;
  logic              rd_pend_r, rd_pend_nxt;
  logic              emit_r, emit_nxt;
  logic [AW-1:0]     emit_idx_r, emit_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;
  logic              move;
  logic              issue;

  assign move  = rd_pend_r && (!out_valid_r || out_tready);
  assign issue = emit_r && (!rd_pend_r || move);
  assign busy  = emit_r || rd_pend_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= store_r[emit_idx_r];
      rd_idx_r  <= emit_idx_r;
    end
    if (move) begin
      out_byte_r <= rd_data_r;
      out_idx_r  <= IDX_W'(rd_idx_r);
      out_last_r <= (rd_idx_r == LAST_IDX);
    end
  end

  always_comb begin
    emit_nxt      = emit_r;
    emit_idx_nxt  = emit_idx_r;
    rd_pend_nxt   = rd_pend_r;
    out_valid_nxt = out_valid_r;
    if (ctl.start) begin
      emit_nxt     = 1'b1;
      emit_idx_nxt = '0;
    end else if (issue) begin
      emit_idx_nxt = emit_idx_r + 1'b1;
      if (emit_idx_r == LAST_IDX) begin
        emit_nxt = 1'b0;
      end
    end
    if (issue) begin
      rd_pend_nxt = 1'b1;
    end else if (move) begin
      rd_pend_nxt = 1'b0;
    end
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r      <= 1'b0;
      emit_idx_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      emit_r      <= emit_nxt;
      emit_idx_r  <= emit_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - BYTE_W - IDX_W){1'b0}}, out_idx_r, out_byte_r};
  assign out_tlast  = out_last_r;

`include "serial_frame_receiver_macros.svh"

  `SFR_ASSERT_NEXT(a_rd_hold, rd_pend_r && !move, rd_pend_r && $stable(rd_data_r))
  `SFR_ASSERT(a_last_idx, out_valid_r && out_last_r, out_idx_r == IDX_W'(FRAME_BYTES - 1))

endmodule

// File: hw/rtl/serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Assembles fixed frames from received bytes and timer ticks, checks them
// and streams good frames out one byte per transaction.
// ----------------------------------------------------------------------------
// Input: one byte or tick per cycle; after a good frame the input stalls
//   while the frame store is read out.
// Output: bytes pass the store read and output registers; one byte per cycle
//   while out_tready is high, paced by the frame store's single read port.
// Reset: control cleared, node_address 0, timeout_ticks 5; the frame store
//   is not cleared.
module serial_frame_receiver #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] byte_value
  input  logic [sfr_pkg::BYTE_W-1:0]      in_tdata,
  // [0] cmd
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] frame_byte, [11:8] byte_index, [15:12] zero
  output logic [sfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::BYTE_W-1:0]      cfg_data
);
  import sfr_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);

  logic [BYTE_W-1:0] node_addr_r, node_addr_nxt;
  logic [BYTE_W-1:0] tmo_ticks_r, tmo_ticks_nxt;
  logic [AW-1:0]     fill_r, fill_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] tleft_r, tleft_nxt;
  logic [BYTE_W-1:0] dest_r, src_r;
  logic              busy;
  logic              in_fire;
  logic              is_byte;
  logic              is_type;
  logic              frame_ok;
  logic [BYTE_W-1:0] rx_byte;
  sfr_ctl_t          ctl;

  assign rx_byte   = in_tdata;
  assign in_tready = !busy;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign is_byte   = in_fire && (in_tuser == CMD_BYTE);
  assign is_type   = (rx_byte == TYPE_Q) || (rx_byte == TYPE_R) || (rx_byte == TYPE_E);
  assign frame_ok  = (sum_r == rx_byte) && (src_r == SOURCE_REQUIRED)
                     && ((dest_r == node_addr_r) || (dest_r == BROADCAST));

  assign ctl.wr_en = is_byte && ((fill_r != '0) || is_type);
  assign ctl.start = is_byte && (fill_r == LAST_IDX) && frame_ok;

  always_ff @(posedge clk) begin
    if (is_byte && (fill_r == AW'(DEST_POS))) begin
      dest_r <= rx_byte;
    end
    if (is_byte && (fill_r == AW'(SRC_POS))) begin
      src_r <= rx_byte;
    end
  end

  always_comb begin
    node_addr_nxt = node_addr_r;
    tmo_ticks_nxt = tmo_ticks_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NODE_ADDRESS:  node_addr_nxt = cfg_data;
        REG_TIMEOUT_TICKS: tmo_ticks_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    tleft_nxt = tleft_r;
    if (in_fire && (in_tuser == CMD_TICK)) begin
      if (tleft_r != '0) begin
        tleft_nxt = tleft_r - 1'b1;
        if (tleft_r == 8'd1) begin
          fill_nxt = '0;
          sum_nxt  = '0;
        end
      end
    end else if (ctl.wr_en) begin
      if (fill_r == LAST_IDX) begin
        fill_nxt  = '0;
        sum_nxt   = '0;
        tleft_nxt = '0;
      end else begin
        fill_nxt  = fill_r + 1'b1;
        sum_nxt   = sum_r + rx_byte;
        tleft_nxt = tmo_ticks_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= '0;
      tmo_ticks_r <= TIMEOUT_RESET;
      fill_r      <= '0;
      sum_r       <= '0;
      tleft_r     <= '0;
    end else begin
      node_addr_r <= node_addr_nxt;
      tmo_ticks_r <= tmo_ticks_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      tleft_r     <= tleft_nxt;
    end
  end

  sfr_drain #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .wr_addr    (fill_r),
    .wr_data    (rx_byte),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`include "serial_frame_receiver_macros.svh"

  `SFR_ASSERT(a_idle_timer_off, fill_r == '0, tleft_r == '0)
  `SFR_ASSERT(a_fill_range, 1'b1, fill_r <= LAST_IDX)
  `SFR_ASSERT_NEXT(a_start_busy, ctl.start, busy && fill_r == '0)

endmodule
